// ===== rtl/bmhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhpq_pkg: shared types and constants of the binary min-heap queue
// Sizes, payload structs, status codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  // Heap sizing
  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned HANDLE_BITS = 16;

  localparam int unsigned ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned CHILD_W = ADDR_W + 2;
  localparam int unsigned KEY_W   = 33;
  localparam int unsigned COST_W  = 32;
  localparam int unsigned HND_W   = 16;
  localparam int unsigned OCC_W   = 11;
  // stored handle bits: the port carries 16, the heap keeps HANDLE_BITS of them
  localparam int unsigned SHW     = (HANDLE_BITS < HND_W) ? HANDLE_BITS : HND_W;

  // Request actions
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Input request
  typedef struct packed {
    logic              action;
    logic [COST_W-1:0] path_cost;
    logic [COST_W-1:0] estimate;
    logic [HND_W-1:0]  node_handle;
  } in_item_t;

  // Result
  typedef struct packed {
    logic [1:0]       status;
    logic [HND_W-1:0] popped_handle;
    logic [KEY_W-1:0] popped_key;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  // One heap entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SHW-1:0]   handle;
  } entry_t;

  // Read address selection of the heap memory
  typedef enum logic [1:0] {
    RD_TOP      = 2'd0,  // root and last entry
    RD_PARENT   = 2'd1,  // parent of the current slot
    RD_CHILDREN = 2'd2   // both children of the current slot
  } rd_sel_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_UP_CHK = 3'd1,
    S_UP_CMP = 3'd2,
    S_POP_LD = 3'd3,
    S_DN_CHK = 3'd4,
    S_DN_CMP = 3'd5,
    S_FINISH = 3'd6
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic    accept;
    logic    pop_load;
    logic    move_up;
    logic    move_down;
    logic    write_item;
    logic    publish;
    rd_sel_e rd_sel;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic go_insert;
    logic go_remove;
    logic pos_zero;
    logic parent_greater;
    logic last_one;
    logic child_exists;
    logic moved_greater;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/binary_min_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue: min-heap keyed by cost plus estimate
// Insert and remove-minimum requests, one result per request.
// ----------------------------------------------------------------------------
// One request at a time. An insert climbs from the new slot toward the root,
// L being the number of heap levels the entry moves (at most 10 with 1024
// entries). A remove takes the root and, unless it empties the heap, moves the
// last entry there and sifts it down, with L at most 9. Each level takes one
// heap memory read (registered) and then a compare and write. After posting
// the result the controller returns to idle before the next request is taken,
// and a result waits for the result register to free up.
// Remove on empty and insert on full go straight to the result stage, report
// their status and change nothing.
// The result register lets the next request be accepted while a result waits.
module binary_min_heap_priority_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bmhpq_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bmhpq_pkg::out_item_t out_item_o
);
  import bmhpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bmhpq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/bmhpq_datapath.sv =====
// ----------------------------------------------------------------------------
// bmhpq_datapath: heap memory, working registers and result register
// Holds the heap array, the entry count, the sift slot and the result.
// ----------------------------------------------------------------------------
module bmhpq_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmhpq_pkg::in_item_t  in_item_i,
  input  bmhpq_pkg::dp_cmd_t   cmd_i,
  output bmhpq_pkg::dp_stat_t  stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bmhpq_pkg::out_item_t out_item_o
);
  import bmhpq_pkg::*;

  // heap memory, two registered read ports, one write port
  entry_t mem [CAPACITY];
  entry_t rd_a_q, rd_b_q;
  logic [ADDR_W-1:0] ra, rb, wa;
  entry_t            wd;
  logic              we;

  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] pos_q;
  status_e           status_q;
  logic [KEY_W-1:0]  key_q;
  logic [SHW-1:0]    hnd_q;
  logic [KEY_W-1:0]  pop_key_q;
  logic [SHW-1:0]    pop_hnd_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              full, empty;
  logic [ADDR_W-1:0] parent_idx, last_idx, sel_idx;
  logic [CHILD_W-1:0] child_l, child_r;
  logic              right_ok, use_right;
  entry_t            sel;

  // index arithmetic
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign parent_idx = (pos_q - ADDR_W'(1)) >> 1;
  assign last_idx   = ADDR_W'(count_q - CNT_W'(1));
  assign child_l    = CHILD_W'({pos_q, 1'b1});
  assign child_r    = child_l + CHILD_W'(1);
  assign right_ok   = (child_r < CHILD_W'(count_q));
  assign use_right  = right_ok && (rd_b_q.key < rd_a_q.key);
  assign sel        = use_right ? rd_b_q : rd_a_q;
  assign sel_idx    = use_right ? child_r[ADDR_W-1:0] : child_l[ADDR_W-1:0];

  // read address mux
  always_comb begin
    case (cmd_i.rd_sel)
      RD_PARENT: begin
        ra = parent_idx;
        rb = parent_idx;
      end
      RD_CHILDREN: begin
        ra = child_l[ADDR_W-1:0];
        rb = child_r[ADDR_W-1:0];
      end
      default: begin
        ra = '0;
        rb = last_idx;
      end
    endcase
  end

  // write port
  always_comb begin
    we = cmd_i.move_up | cmd_i.move_down | cmd_i.write_item;
    wa = pos_q;
    if (cmd_i.move_up) begin
      wd = rd_a_q;
    end else if (cmd_i.move_down) begin
      wd = sel;
    end else begin
      wd = '{key: key_q, handle: hnd_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  // status toward the controller
  always_comb begin
    stat_o.go_insert      = (in_item_i.action == ACT_INSERT) && !full;
    stat_o.go_remove      = (in_item_i.action == ACT_REMOVE) && !empty;
    stat_o.pos_zero       = (pos_q == '0);
    stat_o.parent_greater = (rd_a_q.key > key_q);
    stat_o.last_one       = (count_q == CNT_W'(1));
    stat_o.child_exists   = (child_l < CHILD_W'(count_q));
    stat_o.moved_greater  = (key_q > sel.key);
    stat_o.out_free       = !out_valid_q || out_ready_i;
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (in_item_i.action == ACT_REMOVE) begin
        status_q <= empty ? ST_EMPTY : ST_OK;
      end else begin
        status_q <= full ? ST_FULL : ST_OK;
      end
      key_q     <= KEY_W'(in_item_i.path_cost) + KEY_W'(in_item_i.estimate);
      hnd_q     <= in_item_i.node_handle[SHW-1:0];
      pos_q     <= ADDR_W'(count_q);
      pop_key_q <= '0;
      pop_hnd_q <= '0;
    end else if (cmd_i.pop_load) begin
      pop_key_q <= rd_a_q.key;
      pop_hnd_q <= rd_a_q.handle;
      key_q     <= rd_b_q.key;
      hnd_q     <= rd_b_q.handle;
      pos_q     <= '0;
    end else if (cmd_i.move_up) begin
      pos_q <= parent_idx;
    end else if (cmd_i.move_down) begin
      pos_q <= sel_idx;
    end
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.accept && stat_o.go_insert) begin
      count_q <= count_q + CNT_W'(1);
    end else if (cmd_i.pop_load) begin
      count_q <= count_q - CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.status        <= status_q;
      out_q.popped_handle <= HND_W'(pop_hnd_q);
      out_q.popped_key    <= pop_key_q;
      out_q.occupancy     <= OCC_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/bmhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmhpq_ctrl: sequencer of the heap queue
// Steps one request through sift-up or pop and sift-down, then posts it.
// ----------------------------------------------------------------------------
module bmhpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bmhpq_pkg::dp_stat_t stat_i,
  output bmhpq_pkg::dp_cmd_t  cmd_o
);
  import bmhpq_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_TOP;
    in_ready_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.go_insert) begin
            state_d = S_UP_CHK;
          end else if (stat_i.go_remove) begin
            state_d = S_POP_LD;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      // sift up: fetch parent or settle at the root
      S_UP_CHK: begin
        cmd_o.rd_sel = RD_PARENT;
        if (stat_i.pos_zero) begin
          cmd_o.write_item = 1'b1;
          state_d          = S_FINISH;
        end else begin
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.parent_greater) begin
          cmd_o.move_up = 1'b1;
          state_d       = S_UP_CHK;
        end else begin
          cmd_o.write_item = 1'b1;
          state_d          = S_FINISH;
        end
      end
      // take root, pick up last entry
      S_POP_LD: begin
        cmd_o.pop_load = 1'b1;
        state_d        = stat_i.last_one ? S_FINISH : S_DN_CHK;
      end
      // sift down: fetch children or settle at a leaf
      S_DN_CHK: begin
        cmd_o.rd_sel = RD_CHILDREN;
        if (stat_i.child_exists) begin
          state_d = S_DN_CMP;
        end else begin
          cmd_o.write_item = 1'b1;
          state_d          = S_FINISH;
        end
      end
      S_DN_CMP: begin
        if (stat_i.moved_greater) begin
          cmd_o.move_down = 1'b1;
          state_d         = S_DN_CHK;
        end else begin
          cmd_o.write_item = 1'b1;
          state_d          = S_FINISH;
        end
      end
      // hand the result to the output register once it is free
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
